// ----- src/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg - shared types and codes for the first-fit page allocator
// Holds the request and status codes, the sequencer states and the flag
// group that the shared adder returns to the sequencer.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Request codes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic carry;    // carry out; for a subtraction, set when a >= b
        logic match;    // result equals the compare operand
    } alu_flags_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD,
        S_AL_CHK,
        S_AL_RD,
        S_AL_CMP,
        S_AL_SHR,
        S_AL_TOT,
        S_RM_RD,
        S_RM_WR,
        S_FR_END,
        S_FR_RD,
        S_FR_CMP,
        S_FR_UP,
        S_FR_GROW,
        S_FR_NXT,
        S_FR_ABS,
        S_FR_FULL,
        S_FR_IRD,
        S_FR_ICMP,
        S_IN_RD,
        S_IN_WR,
        S_FR_TOT
    } state_t;

endpackage

// ----- src/ffpa_alu.sv -----
// ----------------------------------------------------------------------------
// ffpa_alu - shared adder and compare unit
// One adder that adds or subtracts, and compares its result with a third
// operand. The sequencer uses it for every sum and ordering test.
// ----------------------------------------------------------------------------
module ffpa_alu
    import ffpa_pkg::*;
#(
    parameter int W = 22
)
(
    input  alu_op_t        op,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    input  logic [W-1:0]   c,
    output logic [W-1:0]   res,
    output alu_flags_t     flags
);

    logic [W-1:0] b_x;
    logic [W:0]   sum;

    always_comb
    begin
        b_x         = (op == ALU_SUB) ? ~b : b;
        sum         = {1'b0, a} + {1'b0, b_x} + {{W{1'b0}}, (op == ALU_SUB)};
        res         = sum[W-1:0];
        flags.carry = sum[W];
        flags.match = (sum[W-1:0] == c);
    end

endmodule

// ----- src/ffpa_extent_ram.sv -----
// ----------------------------------------------------------------------------
// ffpa_extent_ram - extent table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffpa_extent_ram #(
    parameter int DEPTH = 16,
    parameter int DW    = 41,
    parameter int IW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/first_fit_page_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator - first-fit page allocator with coalescing
// Keeps a bounded table of free extents and serves add, allocate and free
// requests with a small sequencer around one shared adder and the table RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Fields
//  --------  -----------------  -------------------------------------------
//  request   start && !busy     mode, region_base, page_count
//  result    done (one cycle)   status, block_base, free_pages_left
//
// An item that is answered at once (a zero count, the unused mode or an
// add to a full table) gets its result straight from the idle state. An
// allocate checks the free total, then reads and compares the extents in
// turn; a used-up extent is removed by moving the entries above it down,
// and a failed allocate stops at the total check or at the end of the scan.
// A free reads each extent in turn and checks both of its ends; when it
// inserts, it scans again for the sorted slot and moves the entries above
// the slot up. The table RAM gives one read at a time with registered read
// data, and every sum and ordering test passes through the single shared
// adder.
// Reset clears the extent count and the free total; the table contents are
// never read before they are written, so no clearing pass is needed.
// The result strobe lasts one cycle and cannot be held off by the receiver;
// busy stays high from the cycle after the accepting edge until the result
// appears, and never rises for an item that is answered at once.
// ----------------------------------------------------------------------------
module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int PAGE_BITS   = 20,
    parameter int MAX_EXTENTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [PAGE_BITS-1:0] region_base,
    input  logic [PAGE_BITS:0]   page_count,
    output logic                 done,
    output logic [1:0]           status,
    output logic [PAGE_BITS-1:0] block_base,
    output logic [PAGE_BITS:0]   free_pages_left
);

    // Lengths carry one bit more than page numbers; a start plus a length
    // needs two more, so the adder is that wide and never wraps.
    localparam int LW = PAGE_BITS + 1;
    localparam int AW = PAGE_BITS + 2;
    localparam int DW = PAGE_BITS + LW;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    // Sequencer and architectural state
    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [LW-1:0]        free_reg, free_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [PAGE_BITS-1:0] block_reg, block_next;

    // Request held for the whole operation, and scan working registers
    logic [1:0]           mode_reg, mode_next;
    logic [PAGE_BITS-1:0] base_reg, base_next;
    logic [LW-1:0]        n_reg, n_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [AW-1:0]        end_reg, end_next;
    logic [PAGE_BITS-1:0] cur_s_reg, cur_s_next;
    logic [LW-1:0]        cur_l_reg, cur_l_next;
    logic [LW-1:0]        aux_l_reg, aux_l_next;

    // Shared adder
    alu_op_t       alu_op;
    logic [AW-1:0] alu_a, alu_b, alu_c, alu_res;
    alu_flags_t    alu_flags;
    logic [LW-1:0] alu_sat;

    // Table RAM
    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;
    logic [PAGE_BITS-1:0] rd_s;
    logic [LW-1:0] rd_l;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] j_dec;

    ffpa_alu #(
        .W (AW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .res   (alu_res),
        .flags (alu_flags)
    );

    ffpa_extent_ram #(
        .DEPTH (MAX_EXTENTS),
        .DW    (DW),
        .IW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A sum of two lengths saturates; its top bit shows that it went past
    // the largest length.
    assign alu_sat = alu_res[AW-1] ? LEN_MAX : alu_res[LW-1:0];
    assign rd_s    = rd_data[DW-1:LW];
    assign rd_l    = rd_data[LW-1:0];
    assign idx_inc = idx_reg + 1'b1;
    assign j_dec   = j_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            cnt_reg    <= '0;
            free_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            block_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            free_reg   <= free_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            block_reg  <= block_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        base_reg  <= base_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        j_reg     <= j_next;
        end_reg   <= end_next;
        cur_s_reg <= cur_s_next;
        cur_l_reg <= cur_l_next;
        aux_l_reg <= aux_l_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        free_next   = free_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        block_next  = block_reg;
        mode_next   = mode_reg;
        base_next   = base_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        end_next    = end_reg;
        cur_s_next  = cur_s_reg;
        cur_l_next  = cur_l_reg;
        aux_l_next  = aux_l_reg;

        alu_op  = ALU_ADD;
        alu_a   = '0;
        alu_b   = '0;
        alu_c   = '0;
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = {cur_s_reg, cur_l_reg};
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    base_next   = region_base;
                    n_next      = page_count;
                    idx_next    = '0;
                    block_next  = '0;
                    status_next = ST_OK;
                    if (mode == MODE_ADD || mode == MODE_ALLOC || mode == MODE_FREE)
                    begin
                        if (page_count == '0)
                        begin
                            status_next = ST_ZERO;
                            done_next   = 1'b1;
                        end
                        else if (mode == MODE_ADD)
                        begin
                            if (cnt_reg >= CW'(MAX_EXTENTS))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        else if (mode == MODE_ALLOC)
                        begin
                            state_next = S_AL_CHK;
                        end
                        else
                        begin
                            state_next = S_FR_END;
                        end
                    end
                    else
                    begin
                        // The unused code changes nothing and reports success.
                        done_next = 1'b1;
                    end
                end
            end

            S_ADD:
            begin
                // Append at the tail, unsorted and unmerged.
                wr_en     = 1'b1;
                wr_addr   = cnt_reg[IW-1:0];
                wr_data   = {base_reg, n_reg};
                cnt_next  = cnt_reg + 1'b1;
                alu_a     = AW'(free_reg);
                alu_b     = AW'(n_reg);
                free_next = alu_sat;
                done_next = 1'b1;
                state_next = S_IDLE;
            end

            S_AL_CHK:
            begin
                alu_op = ALU_SUB;
                alu_a  = AW'(free_reg);
                alu_b  = AW'(n_reg);
                if (!alu_flags.carry)
                begin
                    status_next = ST_NOFIT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_AL_RD;
                end
            end

            S_AL_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    status_next = ST_NOFIT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_AL_CMP;
                end
            end

            S_AL_CMP:
            begin
                alu_op     = ALU_SUB;
                alu_a      = AW'(rd_l);
                alu_b      = AW'(n_reg);
                cur_s_next = rd_s;
                if (!alu_flags.carry)
                begin
                    idx_next   = idx_inc;
                    state_next = S_AL_RD;
                end
                else
                begin
                    block_next = rd_s;
                    aux_l_next = alu_res[LW-1:0];
                    if (alu_flags.match)
                    begin
                        // Exact fit: the extent goes away.
                        ret_next   = S_AL_TOT;
                        state_next = S_RM_RD;
                    end
                    else
                    begin
                        state_next = S_AL_SHR;
                    end
                end
            end

            S_AL_SHR:
            begin
                // The start advance wraps within the page number width.
                alu_a      = AW'(cur_s_reg);
                alu_b      = AW'(n_reg);
                wr_en      = 1'b1;
                wr_data    = {alu_res[PAGE_BITS-1:0], aux_l_reg};
                state_next = S_AL_TOT;
            end

            S_AL_TOT:
            begin
                alu_op     = ALU_SUB;
                alu_a      = AW'(free_reg);
                alu_b      = AW'(n_reg);
                free_next  = alu_res[LW-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_RM_RD:
            begin
                // Close the gap at idx by moving the entries above it down.
                if (idx_inc >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IW-1:0];
                    state_next = S_RM_WR;
                end
            end

            S_RM_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = S_RM_RD;
            end

            S_FR_END:
            begin
                alu_a      = AW'(base_reg);
                alu_b      = AW'(n_reg);
                end_next   = alu_res;
                state_next = S_FR_RD;
            end

            S_FR_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    state_next = S_FR_FULL;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_FR_CMP;
                end
            end

            S_FR_CMP:
            begin
                cur_s_next = rd_s;
                cur_l_next = rd_l;
                if (AW'(rd_s) == end_reg)
                begin
                    // The freed run ends where this extent starts.
                    alu_a      = AW'(rd_l);
                    alu_b      = AW'(n_reg);
                    wr_en      = 1'b1;
                    wr_data    = {base_reg, alu_sat};
                    state_next = S_FR_TOT;
                end
                else
                begin
                    state_next = S_FR_UP;
                end
            end

            S_FR_UP:
            begin
                alu_a = AW'(cur_s_reg);
                alu_b = AW'(cur_l_reg);
                alu_c = AW'(base_reg);
                if (alu_flags.match)
                begin
                    state_next = S_FR_GROW;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FR_RD;
                end
            end

            S_FR_GROW:
            begin
                alu_a      = AW'(cur_l_reg);
                alu_b      = AW'(n_reg);
                cur_l_next = alu_sat;
                wr_en      = 1'b1;
                wr_data    = {cur_s_reg, alu_sat};
                if (idx_inc < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IW-1:0];
                    state_next = S_FR_NXT;
                end
                else
                begin
                    state_next = S_FR_TOT;
                end
            end

            S_FR_NXT:
            begin
                // Does the grown extent now reach the next one?
                alu_a      = AW'(cur_s_reg);
                alu_b      = AW'(cur_l_reg);
                alu_c      = AW'(rd_s);
                aux_l_next = rd_l;
                if (alu_flags.match)
                begin
                    state_next = S_FR_ABS;
                end
                else
                begin
                    state_next = S_FR_TOT;
                end
            end

            S_FR_ABS:
            begin
                alu_a      = AW'(cur_l_reg);
                alu_b      = AW'(aux_l_reg);
                wr_en      = 1'b1;
                wr_data    = {cur_s_reg, alu_sat};
                idx_next   = idx_inc;
                ret_next   = S_FR_TOT;
                state_next = S_RM_RD;
            end

            S_FR_FULL:
            begin
                if (cnt_reg >= CW'(MAX_EXTENTS))
                begin
                    status_next = ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_FR_IRD;
                end
            end

            S_FR_IRD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    j_next     = cnt_reg;
                    state_next = S_IN_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_FR_ICMP;
                end
            end

            S_FR_ICMP:
            begin
                // Insert before the first extent that starts above the run.
                alu_op = ALU_SUB;
                alu_a  = AW'(base_reg);
                alu_b  = AW'(rd_s);
                if (!alu_flags.carry)
                begin
                    j_next     = cnt_reg;
                    state_next = S_IN_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FR_IRD;
                end
            end

            S_IN_RD:
            begin
                if (j_reg > idx_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_dec[IW-1:0];
                    state_next = S_IN_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = {base_reg, n_reg};
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FR_TOT;
                end
            end

            S_IN_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IW-1:0];
                wr_data    = rd_data;
                j_next     = j_dec;
                state_next = S_IN_RD;
            end

            S_FR_TOT:
            begin
                alu_a      = AW'(free_reg);
                alu_b      = AW'(n_reg);
                free_next  = alu_sat;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign block_base      = block_reg;
    assign free_pages_left = free_reg;

    // The table never holds more extents than it has room for.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_EXTENTS))
        else $error("extent count beyond table depth");

    // One operation moves the extent count by at most one.
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == $past(cnt_reg) + 1'b1 || cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("extent count jumped");

    // The free total only changes as a result is delivered.
    a_free_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != $past(free_reg)) |-> done_reg)
        else $error("free total changed without a result");

    // A result appears only once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    // Only a successful allocation reports a block.
    a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK || mode_reg != MODE_ALLOC)) |-> block_reg == '0)
        else $error("block base set without a successful allocation");

endmodule

// ----- verif/tb_first_fit_page_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_allocator - self-checking bench for the page allocator
// Drives add, allocate and free items through the start/busy handshake and
// predicts every result with its own copy of the extent table and the free
// total. Each strobed result is checked field by field against the oldest
// prediction. Directed items cover the status codes, the free merge order
// and the field extremes. Random traffic then allocates blocks and hands
// them back, with some noise mixed in, under random sender gaps.
// ----------------------------------------------------------------------------
module tb_first_fit_page_allocator;

    import ffpa_pkg::*;

    localparam int PAGE_BITS      = 20;
    localparam int MAX_EXTENTS    = 16;
    // A free that scans and then inserts is the slowest item; the window also
    // outlasts the longest sender gap.
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 4000;

    // The block ignores mode three; the package gives it no name.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [PAGE_BITS:0]   len_t;

    // Lengths and the free total saturate at the top of the length field.
    localparam logic [PAGE_BITS+1:0] LEN_LIMIT = {1'b0, {(PAGE_BITS+1){1'b1}}};
    localparam len_t PAGES_MAX = len_t'(1 << PAGE_BITS);

    typedef struct {
        logic [1:0] status;
        page_t      block;
        len_t       left;
    } outcome_t;

    typedef struct {
        page_t base;
        len_t  pages;
    } run_t;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  start       = 1'b0;
    logic  [1:0] mode  = 2'd0;
    page_t region_base = '0;
    len_t  page_count  = '0;
    logic  busy;
    logic  done;
    logic  [1:0] status;
    page_t block_base;
    len_t  free_pages_left;

    // Predicted copy of the allocator state. Entries at or above
    // extent_cnt are never read.
    page_t free_start [MAX_EXTENTS];
    len_t  free_len   [MAX_EXTENTS];
    int    extent_cnt = 0;
    len_t  pages_free = '0;

    // Results still owed by the block, oldest first.
    outcome_t pending_outcomes [$];
    // Blocks the block has handed out and the bench has not yet returned.
    run_t     handed_out [$];

    int mismatches  = 0;
    int idle_cycles = 0;

    first_fit_page_allocator #(
        .PAGE_BITS   (PAGE_BITS),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .region_base     (region_base),
        .page_count      (page_count),
        .done            (done),
        .status          (status),
        .block_base      (block_base),
        .free_pages_left (free_pages_left)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic len_t len_sat_sum(input len_t a, input len_t b);
        logic [PAGE_BITS+1:0] total;
        total = a + b;
        return (total > LEN_LIMIT) ? LEN_LIMIT[PAGE_BITS:0] : total[PAGE_BITS:0];
    endfunction

    task automatic insert_extent(input int at, input page_t s, input len_t l);
        int j;
        for (j = extent_cnt; j > at; j--)
        begin
            free_start[j] = free_start[j-1];
            free_len[j]   = free_len[j-1];
        end
        free_start[at] = s;
        free_len[at]   = l;
        extent_cnt++;
    endtask

    task automatic remove_extent(input int at);
        int j;
        for (j = at; j + 1 < extent_cnt; j++)
        begin
            free_start[j] = free_start[j+1];
            free_len[j]   = free_len[j+1];
        end
        extent_cnt--;
    endtask

    // Works out the result of one accepted item and moves the predicted
    // table on to the state that the block should be in afterwards.
    task automatic predict_outcome(input logic [1:0] op, input page_t base,
                                   input len_t cnt, output outcome_t res);
        logic [PAGE_BITS+1:0] run_end;
        logic [PAGE_BITS+1:0] ext_end;
        int i;
        int slot;
        bit merged;
        res.status = ST_OK;
        res.block  = '0;
        if (op != MODE_UNUSED && cnt == '0)
        begin
            res.status = ST_ZERO;
        end
        else if (op == MODE_ADD)
        begin
            // Adds go on the tail, unsorted and unmerged.
            if (extent_cnt >= MAX_EXTENTS)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                insert_extent(extent_cnt, base, cnt);
                pages_free = len_sat_sum(pages_free, cnt);
            end
        end
        else if (op == MODE_ALLOC)
        begin
            if (cnt > pages_free)
            begin
                res.status = ST_NOFIT;
            end
            else
            begin
                slot = 0;
                while (slot < extent_cnt && free_len[slot] < cnt)
                    slot++;
                if (slot >= extent_cnt)
                begin
                    res.status = ST_NOFIT;
                end
                else
                begin
                    res.block = free_start[slot];
                    if (free_len[slot] > cnt)
                    begin
                        // The start advance wraps within the page field.
                        free_start[slot] = page_t'(free_start[slot] + cnt);
                        free_len[slot]   = free_len[slot] - cnt;
                    end
                    else
                    begin
                        remove_extent(slot);
                    end
                    pages_free = pages_free - cnt;
                end
            end
        end
        else if (op == MODE_FREE)
        begin
            // Adjacency sums are taken one bit wider so that they never wrap.
            merged  = 1'b0;
            run_end = base + cnt;
            for (i = 0; i < extent_cnt && !merged; i++)
            begin
                ext_end = free_start[i] + free_len[i];
                if (run_end == free_start[i])
                begin
                    free_start[i] = base;
                    free_len[i]   = len_sat_sum(free_len[i], cnt);
                    merged        = 1'b1;
                end
                else if (ext_end == base)
                begin
                    free_len[i] = len_sat_sum(free_len[i], cnt);
                    ext_end     = free_start[i] + free_len[i];
                    // The grown entry swallows its successor if they now touch.
                    if (i + 1 < extent_cnt && ext_end == free_start[i+1])
                    begin
                        free_len[i] = len_sat_sum(free_len[i], free_len[i+1]);
                        remove_extent(i + 1);
                    end
                    merged = 1'b1;
                end
            end
            if (!merged)
            begin
                if (extent_cnt >= MAX_EXTENTS)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    slot = 0;
                    while (slot < extent_cnt && free_start[slot] <= base)
                        slot++;
                    insert_extent(slot, base, cnt);
                end
            end
            if (res.status == ST_OK)
                pages_free = len_sat_sum(pages_free, cnt);
        end
        res.left = pages_free;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Presents one item and holds it until the block takes it. Start is left
    // high, so a following call keeps the request line up without a glitch.
    // Every call is made at a rising edge.
    task automatic send_request(input logic [1:0] op, input page_t base,
                                input len_t cnt);
        outcome_t res;
        mode        <= op;
        region_base <= base;
        page_count  <= cnt;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_outcome(op, base, cnt, res);
        pending_outcomes.push_back(res);
        if (op == MODE_ALLOC && res.status == ST_OK)
            handed_out.push_back('{base: res.block, pages: cnt});
    endtask

    // Random idle time after an item: mostly none or a short one, now and
    // then a long stretch.
    task automatic pause_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 45)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 15);
        else
            gap = $urandom_range(30, 80);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drops the request line and waits until every owed result has arrived.
    // The loop waits on the clock before it checks, so start is never lowered
    // and raised in the same step.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    // One random item. Most traffic is allocation and the return of blocks
    // that were handed out; the rest is adds and noise.
    task automatic send_random_request();
        int   r;
        int   k;
        run_t blk;
        len_t n;
        r = $urandom_range(0, 99);
        if (r < 30 && handed_out.size() > 0)
        begin
            k   = $urandom_range(0, handed_out.size() - 1);
            blk = handed_out[k];
            handed_out.delete(k);
            send_request(MODE_FREE, blk.base, blk.pages);
        end
        else if (r < 65 || (r < 80 && extent_cnt > 12))
        begin
            // An exact-length request can use an extent up and shrink the table.
            k = $urandom_range(0, 99);
            if (k < 25 && extent_cnt > 0)
                n = free_len[$urandom_range(0, extent_cnt - 1)];
            else if (k < 90)
                n = len_t'($urandom_range(1, 64));
            else
                n = len_t'($urandom_range(1, PAGES_MAX));
            send_request(MODE_ALLOC, page_t'($urandom), n);
        end
        else if (r < 80)
        begin
            if ($urandom_range(0, 7) == 0)
                n = len_t'($urandom_range(1, PAGES_MAX));
            else
                n = len_t'($urandom_range(1, 256));
            send_request(MODE_ADD, page_t'($urandom), n);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: send_request(2'($urandom_range(0, 3)), page_t'($urandom), '0);
                1: send_request(MODE_UNUSED, page_t'($urandom),
                                len_t'($urandom_range(0, PAGES_MAX)));
                2: send_request(MODE_FREE, page_t'($urandom),
                                len_t'($urandom_range(1, PAGES_MAX)));
                default: send_request(MODE_ALLOC, page_t'($urandom), PAGES_MAX);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // From an empty table: a request above the free total, a zero count in
    // every mode, and the unused mode, which must report ok and do nothing.
    task automatic test_error_codes();
        send_request(MODE_ALLOC, '0, 21'd1);
        send_request(MODE_ADD, 20'd5, '0);
        send_request(MODE_ALLOC, '0, '0);
        pause_sender();
        send_request(MODE_FREE, 20'd7, '0);
        send_request(MODE_UNUSED, '0, '0);
        send_request(MODE_UNUSED, '1, PAGES_MAX);
        wait_for_results();
    endtask

    // Out-of-order adds, both allocate failures, and each way a free can
    // land: joining the entry above it, growing the entry below it,
    // inserting in sorted position, and bridging two entries.
    task automatic test_merge_order();
        send_request(MODE_ADD, 20'd100, 21'd50);
        send_request(MODE_ADD, 20'd16, 21'd16);
        send_request(MODE_ALLOC, '0, 21'd20);
        pause_sender();
        send_request(MODE_ALLOC, '0, 21'd60);
        send_request(MODE_ALLOC, '0, 21'd40);
        send_request(MODE_FREE, 20'd100, 21'd20);
        send_request(MODE_FREE, 20'd32, 21'd8);
        pause_sender();
        send_request(MODE_FREE, 20'd60, 21'd10);
        send_request(MODE_FREE, 20'd70, 21'd30);
        send_request(MODE_ALLOC, '0, 21'd90);
        wait_for_results();
    endtask

    // Largest counts and page numbers: an allocation whose start advance
    // wraps past the top page, and adds that drive the free total into
    // saturation.
    task automatic test_extremes();
        send_request(MODE_ADD, 20'hFFFF0, PAGES_MAX);
        send_request(MODE_ALLOC, '1, 21'd32);
        send_request(MODE_ADD, '0, PAGES_MAX);
        send_request(MODE_ADD, '1, PAGES_MAX);
        send_request(MODE_ALLOC, '0, PAGES_MAX);
        send_request(MODE_FREE, '1, 21'd1);
        wait_for_results();
    endtask

    // Fill every slot with adds, then try an add and a free that both need
    // a new entry, one free that merges, and finally use up a few extents.
    task automatic test_table_full();
        while (extent_cnt < MAX_EXTENTS)
        begin
            send_request(MODE_ADD, page_t'($urandom), len_t'($urandom_range(1, 64)));
            pause_sender();
        end
        send_request(MODE_ADD, page_t'($urandom), 21'd5);
        send_request(MODE_FREE, page_t'($urandom), 21'd1);
        send_request(MODE_FREE, page_t'(free_start[3] + free_len[3]), 21'd1);
        repeat (4)
        begin
            send_request(MODE_ALLOC, '0, free_len[$urandom_range(0, extent_cnt - 1)]);
            pause_sender();
        end
        wait_for_results();
    endtask

    task automatic test_random_with_gaps(input int items);
        repeat (items)
        begin
            send_random_request();
            pause_sender();
        end
        wait_for_results();
    endtask

    // No sender gaps at all, so each item follows its predecessor's result
    // as closely as the block allows.
    task automatic test_back_to_back(input int items);
        repeat (items)
            send_random_request();
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what,
                     want, got);
    endtask

    // Results are sampled at the edge that ends their strobe cycle, before
    // the block's own updates for that edge land.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                note_mismatch("unexpected result, status", '0, 64'(status));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(status));
                if (block_base !== want.block)
                    note_mismatch("block_base", 64'(want.block), 64'(block_base));
                if (free_pages_left !== want.left)
                    note_mismatch("free_pages_left", 64'(want.left),
                                  64'(free_pages_left));
            end
        end
    end

    // Ends a hung run: any cycle in which neither an item nor a result
    // crosses the interface counts towards the limit.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : test_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_error_codes();
        test_merge_order();
        test_extremes();
        test_table_full();
        test_random_with_gaps(950);
        test_back_to_back(400);

        // Any stray strobe in this window shows up as an unexpected result.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
